/* hw/rtl/sau_pkg.sv */
// Shared types and constants of the stack arithmetic unit.
package sau_pkg;

  // Data word and result field widths.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DEPTH_W = 7;
  localparam int unsigned STEP_W  = $clog2(WORD_W);

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  // Command codes of an input word.
  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_POP  = 3'd1,
    ACT_ADD  = 3'd2,
    ACT_SUB  = 3'd3,
    ACT_MUL  = 3'd4,
    ACT_DIV  = 3'd5,
    ACT_DEC  = 3'd6,
    ACT_NOP  = 3'd7
  } action_e;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef enum logic [1:0] {
    AS_IDLE = 2'd0,
    AS_RUN  = 2'd1,
    AS_FIN  = 2'd2
  } alu_state_e;

  typedef enum logic [1:0] {
    CS_IDLE  = 2'd0,
    CS_FETCH = 2'd1,
    CS_ALU   = 2'd2,
    CS_WB    = 2'd3
  } ctl_state_e;

  // Request to and response from the arithmetic unit.
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } alu_rsp_t;

endpackage

/* hw/rtl/sau_stack_mem.sv */
// Stack storage: one write port and one registered read port.
module sau_stack_mem #(
  parameter int unsigned Depth  = 64,
  parameter int unsigned AddrW  = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  sau_pkg::word_t            wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output sau_pkg::word_t            rdata_o
);
  import sau_pkg::*;

  word_t mem_q [Depth];
  word_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sau_alu.sv */
// Shared arithmetic unit: one 33-bit adder used for add, subtract,
// shift-add multiply and restoring divide.
module sau_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sau_pkg::alu_req_t req_i,
  input  sau_pkg::word_t    a_i,
  input  sau_pkg::word_t    b_i,
  output sau_pkg::alu_rsp_t rsp_o
);
  import sau_pkg::*;

  alu_state_e        state_q, state_d;
  alu_op_e           op_q;
  word_t             acc_q;
  word_t             div_q;
  word_t             quo_q;
  word_t             rem_q;
  logic              neg_q;
  logic [STEP_W-1:0] cnt_q;

  logic [WORD_W:0]   opa;
  logic [WORD_W:0]   opb;
  logic              sub;
  logic [WORD_W+1:0] sum;
  logic              no_borrow;
  logic              last;
  word_t             abs_a;
  word_t             abs_b;

  // Magnitudes of the divide operands.
  assign abs_a = a_i[WORD_W-1] ? (WORD_W'(0) - a_i) : a_i;
  assign abs_b = b_i[WORD_W-1] ? (WORD_W'(0) - b_i) : b_i;

  // The one adder, shared by every operation.
  always_comb begin
    if (op_q == ALU_DIV) begin
      opa = {rem_q, quo_q[WORD_W-1]};
    end else begin
      opa = {1'b0, acc_q};
    end
    opb       = {1'b0, div_q};
    sub       = (op_q == ALU_SUB) || (op_q == ALU_DIV);
    sum       = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (WORD_W+2)'(sub);
    no_borrow = sum[WORD_W+1];
    last      = (op_q == ALU_ADD) || (op_q == ALU_SUB) || (cnt_q == '1);
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          state_d = AS_RUN;
        end
      end
      AS_RUN: begin
        if (last) begin
          state_d = AS_FIN;
        end
      end
      AS_FIN:  state_d = AS_IDLE;
      default: state_d = AS_IDLE;
    endcase
  end

  // Datapath: load operands on start, then one adder step per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == AS_IDLE && req_i.start) begin
      op_q  <= req_i.op;
      cnt_q <= '0;
      rem_q <= '0;
      neg_q <= a_i[WORD_W-1] ^ b_i[WORD_W-1];
      case (req_i.op)
        ALU_MUL: begin
          acc_q <= '0;
          div_q <= a_i;
          quo_q <= b_i;
        end
        ALU_DIV: begin
          acc_q <= '0;
          div_q <= abs_b;
          quo_q <= abs_a;
        end
        default: begin
          acc_q <= a_i;
          div_q <= b_i;
          quo_q <= '0;
        end
      endcase
    end else if (state_q == AS_RUN) begin
      cnt_q <= cnt_q + STEP_W'(1);
      case (op_q)
        ALU_MUL: begin
          if (quo_q[0]) begin
            acc_q <= sum[WORD_W-1:0];
          end
          div_q <= {div_q[WORD_W-2:0], 1'b0};
          quo_q <= {1'b0, quo_q[WORD_W-1:1]};
        end
        ALU_DIV: begin
          if (no_borrow) begin
            rem_q <= sum[WORD_W-1:0];
          end else begin
            rem_q <= opa[WORD_W-1:0];
          end
          quo_q <= {quo_q[WORD_W-2:0], no_borrow};
        end
        default: begin
          acc_q <= sum[WORD_W-1:0];
        end
      endcase
    end
  end

  // Result, with the quotient sign applied at the end.
  always_comb begin
    rsp_o.done = (state_q == AS_FIN);
    if (op_q == ALU_DIV) begin
      rsp_o.result = neg_q ? (WORD_W'(0) - quo_q) : quo_q;
    end else begin
      rsp_o.result = acc_q;
    end
  end

endmodule

/* hw/rtl/stack_arithmetic_unit.sv */
// Stack arithmetic unit top level: command sequencer, stack and output register.
//
// The unit keeps a stack of signed 32-bit words and takes one command word at a
// time: push, pop, add, subtract, multiply, divide (second entry op top entry,
// both replaced by the result) or decrement the top. Every command returns one
// result word with the new top (zero when empty), the depth and a status; an
// underflow, overflow or divide by zero leaves the stack unchanged. Push, no-op
// and any error go straight to write-back; pop reads the entry below the top;
// decrement runs the shared adder; the others read that entry, then the adder,
// whose radix-2 shift-add and restoring-divide loop takes one bit per cycle.
// A finished result waits in the output register while the next command is
// taken; the stack memory is not cleared after reset.
module stack_arithmetic_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              action_i,
  input  logic signed [31:0]      push_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [31:0]      top_value_o,
  output logic [6:0]              depth_o,
  output logic [1:0]              status_o
);
  import sau_pkg::*;

  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  ctl_state_e       state_q, state_d;
  logic [SpW-1:0]   sp_q, sp_new;
  word_t            top_q, top_new;
  action_e          act_q;
  word_t            res_q;
  status_e          status_q;

  logic             in_accept;
  action_e          act_in;
  status_e          status_in;
  logic             commit;
  logic             out_free;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  word_t            mem_rdata;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  word_t            alu_a;
  word_t            alu_b;

  logic             out_valid_q;
  word_t            out_top_q;
  depth_t           out_depth_q;
  status_e          out_status_q;

  assign act_in     = action_e'(action_i);
  assign in_stall_o = (state_q != CS_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !(out_valid_q && out_stall_i);
  assign commit     = (state_q == CS_WB) && out_free;

  // Status of an incoming command, judged from the current depth and top.
  always_comb begin
    status_in = ST_OK;
    case (act_in)
      ACT_PUSH: begin
        if (sp_q == SpW'(STACK_DEPTH)) status_in = ST_OVER;
      end
      ACT_POP, ACT_DEC: begin
        if (sp_q == '0) status_in = ST_UNDER;
      end
      ACT_ADD, ACT_SUB, ACT_MUL: begin
        if (sp_q < SpW'(2)) status_in = ST_UNDER;
      end
      ACT_DIV: begin
        if (sp_q < SpW'(2)) begin
          status_in = ST_UNDER;
        end else if (top_q == '0) begin
          status_in = ST_DIVZ;
        end
      end
      default: status_in = ST_OK;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and requests to the arithmetic unit.
  always_comb begin
    state_d       = state_q;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_SUB;
    alu_a         = top_q;
    alu_b         = WORD_W'(1);
    unique case (state_q)
      CS_IDLE: begin
        if (in_accept) begin
          if (status_in != ST_OK) begin
            state_d = CS_WB;
          end else begin
            case (act_in)
              ACT_POP, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: state_d = CS_FETCH;
              ACT_DEC: begin
                alu_req.start = 1'b1;
                state_d       = CS_ALU;
              end
              default: state_d = CS_WB;
            endcase
          end
        end
      end
      CS_FETCH: begin
        alu_a = mem_rdata;
        alu_b = top_q;
        case (act_q)
          ACT_ADD: alu_req.op = ALU_ADD;
          ACT_MUL: alu_req.op = ALU_MUL;
          ACT_DIV: alu_req.op = ALU_DIV;
          default: alu_req.op = ALU_SUB;
        endcase
        if (act_q == ACT_POP) begin
          state_d = CS_WB;
        end else begin
          alu_req.start = 1'b1;
          state_d       = CS_ALU;
        end
      end
      CS_ALU: begin
        if (alu_rsp.done) begin
          state_d = CS_WB;
        end
      end
      CS_WB: begin
        if (out_free) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Command word and working result.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q    <= act_in;
      res_q    <= push_value_i;
      status_q <= status_in;
    end else if (state_q == CS_FETCH && act_q == ACT_POP) begin
      res_q <= mem_rdata;
    end else if (state_q == CS_ALU && alu_rsp.done) begin
      res_q <= alu_rsp.result;
    end
  end

  // New stack pointer, top and memory write of a committing command.
  always_comb begin
    sp_new    = sp_q;
    top_new   = top_q;
    mem_we    = 1'b0;
    mem_waddr = AddrW'(sp_q - SpW'(2));
    if (status_q == ST_OK) begin
      case (act_q)
        ACT_PUSH: begin
          sp_new    = sp_q + SpW'(1);
          top_new   = res_q;
          mem_we    = commit;
          mem_waddr = AddrW'(sp_q);
        end
        ACT_POP: begin
          sp_new  = sp_q - SpW'(1);
          top_new = res_q;
        end
        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
          sp_new  = sp_q - SpW'(1);
          top_new = res_q;
          mem_we  = commit;
        end
        ACT_DEC: begin
          top_new   = res_q;
          mem_we    = commit;
          mem_waddr = AddrW'(sp_q - SpW'(1));
        end
        default: begin
          sp_new = sp_q;
        end
      endcase
    end
  end

  // The only read ever needed is the entry below the top.
  assign mem_raddr = AddrW'(sp_q - SpW'(2));

  // Stack pointer and cached top entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (commit) begin
      sp_q <= sp_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      top_q <= top_new;
    end
  end

  // Output register: holds a result word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_top_q    <= (sp_new == '0) ? '0 : top_new;
      out_depth_q  <= depth_t'(sp_new);
      out_status_q <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;
  assign status_o    = out_status_q;

  sau_stack_mem #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (res_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sau_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp_o  (alu_rsp)
  );

endmodule
